/* design/csva_pkg.sv */
// ----------------------------------------------------------------------------
// csva_pkg
// Shared types, command codes and saturating add for the complex spinor
// vector ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package csva_pkg;

  typedef enum logic [3:0] {
    CMD_ADD       = 4'd0,
    CMD_SUB       = 4'd1,
    CMD_COPY      = 4'd2,
    CMD_AXPY      = 4'd3,
    CMD_AXPY_RE   = 4'd4,
    CMD_AXMY      = 4'd5,
    CMD_SCALE_ADD = 4'd6,
    CMD_SCALE_RE  = 4'd7,
    CMD_SCALE     = 4'd8,
    CMD_DOT       = 4'd9,
    CMD_REALDOT   = 4'd10,
    CMD_NORM      = 4'd11,
    CMD_GAMMA5    = 4'd12,
    CMD_ZERO      = 4'd13
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_ELEM,
    CLS_GAMMA,
    CLS_RED,
    CLS_ZERO
  } cls_e;

  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_RE = 4'd0,
    REG_COEF_IM = 4'd1
  } reg_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] a_s1_re;
    logic signed [31:0] a_s1_im;
    logic signed [31:0] a_s2_re;
    logic signed [31:0] a_s2_im;
    logic signed [31:0] b_s1_re;
    logic signed [31:0] b_s1_im;
    logic signed [31:0] b_s2_re;
    logic signed [31:0] b_s2_im;
    logic               is_last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_s1_re;
    logic signed [31:0] out_s1_im;
    logic signed [31:0] out_s2_re;
    logic signed [31:0] out_s2_im;
    logic signed [63:0] sum_re;
    logic signed [63:0] sum_im;
    logic               sum_valid;
    logic               saturated;
  } out_t;

  typedef struct packed {
    cls_e cls;
    cmd_e cmd;
    in_t  data;
  } item_t;

  typedef struct packed {
    logic               clip;
    logic signed [63:0] val;
  } sadd_t;

  function automatic sadd_t sadd64(input logic signed [63:0] a, input logic signed [63:0] b);
    sadd_t              r;
    logic signed [63:0] s;
    s      = a + b;
    r.clip = (a[63] == b[63]) && (s[63] != a[63]);
    if (r.clip) begin
      r.val = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r.val = s;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/complex_spinor_vector_alu_core.sv */
// ----------------------------------------------------------------------------
// complex_spinor_vector_alu_core
// Streaming complex BLAS-1 unit: element ops, dot, realdot and norm.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     push / full          in_data_i  (csva_pkg::in_t)
// result    empty / pop          result_o   (csva_pkg::out_t)
// config    cfg_valid/cfg_ready  cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while the result queue is not full; a result reaches
// the ports through the input queue, multiply stage, combine/accumulate stage and result queue.
// Accumulators update in the combine stage, one element per cycle unless stalled.
// Reset clears queues, pipeline valids, accumulators and coefficients.
// A full result queue stalls the back end; the input queue absorbs it.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_spinor_vector_alu_core #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  csva_pkg::in_t                     in_data_i,
  output logic                              empty,
  input  logic                              pop,
  output csva_pkg::out_t                    result_o,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csva_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  logic signed [31:0] coef_re_q, coef_im_q;
  csva_pkg::item_t    fe_item, q_item;
  logic               fe_wr, q_full, q_empty, q_rd;
  csva_pkg::out_t     be_res;
  logic               be_wr, o_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_re_q <= '0;
      coef_im_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index_i == csva_pkg::REG_COEF_RE) begin
        coef_re_q <= cfg_data_i;
      end
      if (cfg_index_i == csva_pkg::REG_COEF_IM) begin
        coef_im_q <= cfg_data_i;
      end
    end
  end

  csva_front u_front (
    .in_data_i (in_data_i),
    .push_i    (push),
    .full_o    (full),
    .q_full_i  (q_full),
    .wr_o      (fe_wr),
    .item_o    (fe_item)
  );

  csva_fifo #(
    .T     (csva_pkg::item_t),
    .DEPTH (4)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fe_wr),
    .wdata_i (fe_item),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_item),
    .empty_o (q_empty)
  );

  csva_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (q_item),
    .avail_i    (!q_empty),
    .rd_o       (q_rd),
    .coef_re_i  (coef_re_q),
    .coef_im_i  (coef_im_q),
    .res_o      (be_res),
    .res_wr_o   (be_wr),
    .res_full_i (o_full)
  );

  csva_fifo #(
    .T     (csva_pkg::out_t),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (be_wr),
    .wdata_i (be_res),
    .full_o  (o_full),
    .rd_i    (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

/* design/csva_front.sv */
// ----------------------------------------------------------------------------
// csva_front
// Input side: takes beats and tags each with its operation class.
// ----------------------------------------------------------------------------
`default_nettype none

module csva_front (
  input  var csva_pkg::in_t   in_data_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic                q_full_i,
  output logic                wr_o,
  output csva_pkg::item_t     item_o
);

  assign full_o = q_full_i;
  assign wr_o   = push_i && !q_full_i;

  always_comb begin
    item_o.data = in_data_i;
    item_o.cmd  = csva_pkg::CMD_ZERO;
    item_o.cls  = csva_pkg::CLS_ZERO;
    unique case (in_data_i.cmd)
      csva_pkg::CMD_ADD, csva_pkg::CMD_SUB, csva_pkg::CMD_COPY, csva_pkg::CMD_AXPY,
      csva_pkg::CMD_AXPY_RE, csva_pkg::CMD_AXMY, csva_pkg::CMD_SCALE_ADD,
      csva_pkg::CMD_SCALE_RE, csva_pkg::CMD_SCALE: begin
        item_o.cmd = csva_pkg::cmd_e'(in_data_i.cmd);
        item_o.cls = csva_pkg::CLS_ELEM;
      end
      csva_pkg::CMD_DOT, csva_pkg::CMD_REALDOT, csva_pkg::CMD_NORM: begin
        item_o.cmd = csva_pkg::cmd_e'(in_data_i.cmd);
        item_o.cls = csva_pkg::CLS_RED;
      end
      csva_pkg::CMD_GAMMA5: begin
        item_o.cmd = csva_pkg::CMD_GAMMA5;
        item_o.cls = csva_pkg::CLS_GAMMA;
      end
      default: begin
        item_o.cmd = csva_pkg::CMD_ZERO;
        item_o.cls = csva_pkg::CLS_ZERO;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/csva_fifo.sv */
// ----------------------------------------------------------------------------
// csva_fifo
// Small flop-based queue; DEPTH is a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module csva_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic rd_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T               mem_q [DEPTH];
  logic [AW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]    cnt_q, cnt_d;
  logic           do_wr, do_rd;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? wptr_q + AW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + AW'(1) : rptr_q;
    cnt_d  = cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* design/csva_back.sv */
// ----------------------------------------------------------------------------
// csva_back
// Execution side: multiply stage, then combine/saturate and accumulate stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csva_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csva_pkg::item_t    item_i,
  input  logic               avail_i,
  output logic               rd_o,
  input  logic signed [31:0] coef_re_i,
  input  logic signed [31:0] coef_im_i,
  output csva_pkg::out_t     res_o,
  output logic               res_wr_o,
  input  logic               res_full_i
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

  logic                 en;
  logic                 s1_v_q;
  csva_pkg::cls_e       s1_cls_q;
  csva_pkg::cmd_e       s1_cmd_q;
  logic                 s1_last_q;
  logic signed [DW-1:0] s1_a_q [4];
  logic signed [DW-1:0] s1_b_q [4];
  logic signed [63:0]   s1_m_q [2][4];
  logic signed [63:0]   m_d    [2][4];
  logic signed [DW-1:0] a_x [4];
  logic signed [DW-1:0] b_x [4];
  logic signed [DW-1:0] cr, ci;

  logic                 s2_v_q;
  csva_pkg::out_t       s2_q, s2_d;
  logic signed [63:0]   acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic                 clip_q, clip_d;

  assign en       = !s2_v_q || !res_full_i;
  assign rd_o     = en && avail_i;
  assign res_o    = s2_q;
  assign res_wr_o = s2_v_q;
  assign cr       = coef_re_i[DW-1:0];
  assign ci       = coef_im_i[DW-1:0];

  // operand pick and products
  always_comb begin
    logic signed [DW-1:0] ar, ai, br, bi;
    logic signed [DW-1:0] x [4];
    logic signed [DW-1:0] y [4];
    a_x[0] = item_i.data.a_s1_re[DW-1:0];
    a_x[1] = item_i.data.a_s1_im[DW-1:0];
    a_x[2] = item_i.data.a_s2_re[DW-1:0];
    a_x[3] = item_i.data.a_s2_im[DW-1:0];
    b_x[0] = item_i.data.b_s1_re[DW-1:0];
    b_x[1] = item_i.data.b_s1_im[DW-1:0];
    b_x[2] = item_i.data.b_s2_re[DW-1:0];
    b_x[3] = item_i.data.b_s2_im[DW-1:0];
    for (int k = 0; k < 2; k++) begin
      ar = a_x[2*k];
      ai = a_x[2*k+1];
      br = b_x[2*k];
      bi = b_x[2*k+1];
      if (item_i.cls == csva_pkg::CLS_RED) begin
        if (item_i.cmd == csva_pkg::CMD_NORM) begin
          x[0] = br; y[0] = br;
          x[1] = bi; y[1] = bi;
        end else begin
          x[0] = ar; y[0] = br;
          x[1] = ai; y[1] = bi;
        end
        x[2] = ar; y[2] = bi;
        x[3] = ai; y[3] = br;
      end else begin
        if (item_i.cmd == csva_pkg::CMD_SCALE_ADD) begin
          x[0] = cr; y[0] = ar;
          x[1] = cr; y[1] = ai;
        end else begin
          x[0] = cr; y[0] = br;
          x[1] = ci; y[1] = bi;
        end
        x[2] = cr; y[2] = bi;
        x[3] = ci; y[3] = br;
      end
      for (int j = 0; j < 4; j++) begin
        m_d[k][j] = 64'(PW'(x[j]) * PW'(y[j]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && avail_i) begin
      s1_cls_q  <= item_i.cls;
      s1_cmd_q  <= item_i.cmd;
      s1_last_q <= item_i.data.is_last;
      s1_a_q    <= a_x;
      s1_b_q    <= b_x;
      s1_m_q    <= m_d;
    end
  end

  // combine, saturate, accumulate
  always_comb begin
    logic signed [65:0]   ar, ai, br, bi, tr, ti, re, im;
    logic signed [65:0]   r [4];
    logic signed [DW-1:0] o [4];
    logic                 flag;
    csva_pkg::sadd_t      sr, si;
    logic                 aclip;
    flag     = 1'b0;
    aclip    = 1'b0;
    sr       = '0;
    si       = '0;
    s2_d     = '0;
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    clip_d   = clip_q;
    for (int k = 0; k < 2; k++) begin
      ar = 66'(s1_a_q[2*k]);
      ai = 66'(s1_a_q[2*k+1]);
      br = 66'(s1_b_q[2*k]);
      bi = 66'(s1_b_q[2*k+1]);
      for (int j = 0; j < 4; j++) begin
        r[j] = 66'(s1_m_q[k][j] >>> FRAC_BITS)
             + (s1_m_q[k][j][FRAC_BITS-1] ? 66'sd1 : 66'sd0);
      end
      tr = r[0] - r[1];
      ti = r[2] + r[3];
      re = '0;
      im = '0;
      unique case (s1_cmd_q)
        csva_pkg::CMD_ADD:       begin re = ar + br;   im = ai + bi;   end
        csva_pkg::CMD_SUB:       begin re = ar - br;   im = ai - bi;   end
        csva_pkg::CMD_COPY:      begin re = br;        im = bi;        end
        csva_pkg::CMD_AXPY:      begin re = ar + tr;   im = ai + ti;   end
        csva_pkg::CMD_AXPY_RE:   begin re = ar + r[0]; im = ai + r[2]; end
        csva_pkg::CMD_AXMY:      begin re = ar - tr;   im = ai - ti;   end
        csva_pkg::CMD_SCALE_ADD: begin re = r[0] + br; im = r[1] + bi; end
        csva_pkg::CMD_SCALE_RE:  begin re = r[0];      im = r[2];      end
        csva_pkg::CMD_SCALE:     begin re = tr;        im = ti;        end
        csva_pkg::CMD_GAMMA5: begin
          re = (k == 0) ? br : -br;
          im = (k == 0) ? bi : -bi;
        end
        default: begin re = '0; im = '0; end
      endcase
      if (re > SAT_HI) begin
        o[2*k] = DW'(SAT_HI); flag = 1'b1;
      end else if (re < SAT_LO) begin
        o[2*k] = DW'(SAT_LO); flag = 1'b1;
      end else begin
        o[2*k] = DW'(re);
      end
      if (im > SAT_HI) begin
        o[2*k+1] = DW'(SAT_HI); flag = 1'b1;
      end else if (im < SAT_LO) begin
        o[2*k+1] = DW'(SAT_LO); flag = 1'b1;
      end else begin
        o[2*k+1] = DW'(im);
      end
    end

    if (s1_cls_q == csva_pkg::CLS_RED) begin
      sr.val = acc_re_q;
      si.val = acc_im_q;
      for (int k = 0; k < 2; k++) begin
        sr = csva_pkg::sadd64(sr.val, s1_m_q[k][0]);
        aclip |= sr.clip;
        sr = csva_pkg::sadd64(sr.val, s1_m_q[k][1]);
        aclip |= sr.clip;
        if (s1_cmd_q == csva_pkg::CMD_DOT) begin
          si = csva_pkg::sadd64(si.val, s1_m_q[k][2]);
          aclip |= si.clip;
          si = csva_pkg::sadd64(si.val, -s1_m_q[k][3]);
          aclip |= si.clip;
        end
      end
      s2_d.saturated = clip_q | aclip;
      if (s1_last_q) begin
        s2_d.sum_re    = sr.val;
        s2_d.sum_im    = (s1_cmd_q == csva_pkg::CMD_DOT) ? si.val : '0;
        s2_d.sum_valid = 1'b1;
        acc_re_d       = '0;
        acc_im_d       = '0;
        clip_d         = 1'b0;
      end else begin
        acc_re_d = sr.val;
        acc_im_d = si.val;
        clip_d   = clip_q | aclip;
      end
    end else begin
      s2_d.out_s1_re = 32'(o[0]);
      s2_d.out_s1_im = 32'(o[1]);
      s2_d.out_s2_re = 32'(o[2]);
      s2_d.out_s2_im = 32'(o[3]);
      s2_d.saturated = flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q   <= 1'b0;
      acc_re_q <= '0;
      acc_im_q <= '0;
      clip_q   <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        acc_re_q <= acc_re_d;
        acc_im_q <= acc_im_d;
        clip_q   <= clip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

endmodule

`default_nettype wire

/* design/csva_checker.sv */
// ----------------------------------------------------------------------------
// csva_checker
// Port-level checks on the result channel and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module csva_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           full,
  input logic           empty,
  input logic           pop,
  input csva_pkg::out_t result_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !result_o.sum_valid |-> result_o.sum_re == '0 && result_o.sum_im == '0)
    else $error("sum nonzero without sum_valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.sum_valid |->
      result_o.out_s1_re == '0 && result_o.out_s1_im == '0 &&
      result_o.out_s2_re == '0 && result_o.out_s2_im == '0)
    else $error("element fields nonzero on reduction result");

  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty && !full)
    else $error("queues not cleared by reset");

endmodule

bind complex_spinor_vector_alu_core csva_checker u_csva_checker (.*);

`default_nettype wire
